// ===== rtl/core/cca_pkg.sv =====
// ----------------------------------------------------------------------------
// cca_pkg: shared types and constants for the cave cellular automaton unit
// Payload structs, configuration struct, controller/datapath command and
// status groups, register map and arithmetic constants.
// ----------------------------------------------------------------------------
`default_nettype none

package cca_pkg;

   // grid size defaults
   localparam int MAX_WIDTH_DEF  = 128;
   localparam int MAX_HEIGHT_DEF = 128;

   // configuration port
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   typedef enum logic [2:0] {
      REG_GRID_WIDTH     = 3'd0,
      REG_GRID_HEIGHT    = 3'd1,
      REG_PASS_COUNT     = 3'd2,
      REG_FILL_PERCENT   = 3'd3,
      REG_WALL_THRESHOLD = 3'd4
   } cca_reg_type;

   localparam logic [7:0] GRID_WIDTH_RST     = 8'd64;
   localparam logic [7:0] GRID_HEIGHT_RST    = 8'd64;
   localparam logic [3:0] PASS_COUNT_RST     = 4'd5;
   localparam logic [6:0] FILL_PERCENT_RST   = 7'd45;
   localparam logic [3:0] WALL_THRESHOLD_RST = 4'd4;

   // request kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // word mod 100: fold bytes with 256^k mod 100, then reciprocal multiply
   localparam int PERCENT_MOD  = 100;
   localparam int BYTE1_WEIGHT = 56;
   localparam int BYTE2_WEIGHT = 36;
   localparam int BYTE3_WEIGHT = 16;
   localparam int RECIP_MUL    = 5243;
   localparam int RECIP_SHIFT  = 19;
   localparam int FOLD_W       = 15;
   localparam int QUO_W        = 9;

   // response queue
   localparam int RSP_DEPTH = 4;

   typedef struct packed {
      logic        req_type;
      logic [31:0] rand_word;
      logic [6:0]  read_x;
      logic [6:0]  read_y;
   } cca_req_type;

   typedef struct packed {
      logic wall;
      logic not_ready;
   } cca_rsp_type;

   typedef struct packed {
      logic [7:0] grid_width;
      logic [7:0] grid_height;
      logic [3:0] pass_count;
      logic [6:0] fill_percent;
      logic [3:0] wall_threshold;
   } cca_cfg_type;

   // which row of the 3x3 window a fetch reads
   typedef enum logic [1:0] {
      STEP_ABOVE = 2'd0,
      STEP_SAME  = 2'd1,
      STEP_BELOW = 2'd2
   } cca_step_type;

   typedef struct packed {
      logic         hold;
      logic         pass_init;
      logic         pass_begin;
      logic         fetch;
      cca_step_type fetch_step;
      logic         calc;
      logic         row_next;
      logic         pass_next;
      logic         set_ready;
   } cca_cmd_type;

   typedef struct packed {
      logic load_last;
      logic load_busy;
      logic pass_zero;
      logic col_last;
      logic row_last;
   } cca_stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/cca_csr.sv =====
// ----------------------------------------------------------------------------
// cca_csr: configuration registers
// APB-style register file holding grid size, pass count, fill and threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module cca_csr
   import cca_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [CSR_DW-1:0] pwdata,
   output logic      [CSR_DW-1:0] prdata,
   output logic                   pready,
   output cca_cfg_type            cfg
);

   logic [7:0] grid_width_ff;
   logic [7:0] grid_height_ff;
   logic [3:0] pass_count_ff;
   logic [6:0] fill_percent_ff;
   logic [3:0] wall_threshold_ff;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff     <= GRID_WIDTH_RST;
         grid_height_ff    <= GRID_HEIGHT_RST;
         pass_count_ff     <= PASS_COUNT_RST;
         fill_percent_ff   <= FILL_PERCENT_RST;
         wall_threshold_ff <= WALL_THRESHOLD_RST;
      end else if (wr_en) begin
         case (paddr[4:2])
            REG_GRID_WIDTH:     grid_width_ff     <= pwdata[7:0];
            REG_GRID_HEIGHT:    grid_height_ff    <= pwdata[7:0];
            REG_PASS_COUNT:     pass_count_ff     <= pwdata[3:0];
            REG_FILL_PERCENT:   fill_percent_ff   <= pwdata[6:0];
            REG_WALL_THRESHOLD: wall_threshold_ff <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_GRID_WIDTH:     prdata = CSR_DW'(grid_width_ff);
         REG_GRID_HEIGHT:    prdata = CSR_DW'(grid_height_ff);
         REG_PASS_COUNT:     prdata = CSR_DW'(pass_count_ff);
         REG_FILL_PERCENT:   prdata = CSR_DW'(fill_percent_ff);
         REG_WALL_THRESHOLD: prdata = CSR_DW'(wall_threshold_ff);
         default:            prdata = '0;
      endcase
   end

   assign cfg.grid_width     = grid_width_ff;
   assign cfg.grid_height    = grid_height_ff;
   assign cfg.pass_count     = pass_count_ff;
   assign cfg.fill_percent   = fill_percent_ff;
   assign cfg.wall_threshold = wall_threshold_ff;

endmodule

`default_nettype wire

// ===== rtl/core/cca_ctrl.sv =====
// ----------------------------------------------------------------------------
// cca_ctrl: sequencer for load drain and relaxation sweeps
// Walks each pass row by row, column by column: three fetches, a settle
// state for the last read, then the cell update.
// ----------------------------------------------------------------------------
`default_nettype none

module cca_ctrl
   import cca_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cca_stat_type stat,
   output cca_cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_CHECK,
      ST_FETCH_ABOVE,
      ST_FETCH_SAME,
      ST_FETCH_BELOW,
      ST_SETTLE,
      ST_CALC
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (stat.load_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.hold = 1'b1;
            // last load write must land before sweeping
            if (!stat.load_busy) begin
               cmd.pass_init = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.hold = 1'b1;
            if (stat.pass_zero) begin
               cmd.set_ready = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.pass_begin = 1'b1;
               state_in       = ST_FETCH_ABOVE;
            end
         end
         ST_FETCH_ABOVE: begin
            cmd.hold       = 1'b1;
            cmd.fetch      = 1'b1;
            cmd.fetch_step = STEP_ABOVE;
            state_in       = ST_FETCH_SAME;
         end
         ST_FETCH_SAME: begin
            cmd.hold       = 1'b1;
            cmd.fetch      = 1'b1;
            cmd.fetch_step = STEP_SAME;
            state_in       = ST_FETCH_BELOW;
         end
         ST_FETCH_BELOW: begin
            cmd.hold       = 1'b1;
            cmd.fetch      = 1'b1;
            cmd.fetch_step = STEP_BELOW;
            state_in       = ST_SETTLE;
         end
         ST_SETTLE: begin
            cmd.hold = 1'b1;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            cmd.hold = 1'b1;
            cmd.calc = 1'b1;
            if (stat.col_last) begin
               if (stat.row_last) begin
                  cmd.pass_next = 1'b1;
                  state_in      = ST_CHECK;
               end else begin
                  cmd.row_next = 1'b1;
                  state_in     = ST_FETCH_ABOVE;
               end
            end else begin
               state_in = ST_FETCH_ABOVE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/cca_datapath.sv =====
// ----------------------------------------------------------------------------
// cca_datapath: cell memory, load pipeline, sweep window and response queue
// Two one-bit banks hold the live and the next grid; a 3x3 window slides
// along each row during a pass.
// ----------------------------------------------------------------------------
`default_nettype none

module cca_datapath
   import cca_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cca_cfg_type cfg,
   input  wire cca_cmd_type cmd,
   output cca_stat_type     stat,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire cca_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output cca_rsp_type      rsp_data
);

   localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(CELLS);
   localparam int LW    = $clog2(CELLS + 1);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int EW    = (WW > 8) ? WW : 8;
   localparam int EH    = (HW > 8) ? HW : 8;
   localparam int XW    = (WW > 7) ? WW : 7;
   localparam int YW    = (HW > 7) ? HW : 7;
   localparam int PW    = WW + HW;
   localparam int RW    = 7 + WW + 1;
   localparam int MW    = FOLD_W + 13;
   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   // ---------------- effective grid size ----------------
   logic [EW-1:0] w_cfg;
   logic [EH-1:0] h_cfg;
   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   logic [PW-1:0] total;

   assign w_cfg = EW'(cfg.grid_width);
   assign h_cfg = EH'(cfg.grid_height);

   always_comb begin
      if (w_cfg == '0) begin
         w_eff = WW'(1);
      end else if (w_cfg > EW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(w_cfg);
      end
      if (h_cfg == '0) begin
         h_eff = HW'(1);
      end else if (h_cfg > EH'(MAX_HEIGHT)) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(h_cfg);
      end
   end

   assign total = PW'(w_eff) * PW'(h_eff);

   // ---------------- request side ----------------
   logic             req_acc;
   logic             ld_acc;
   logic             rd_acc;
   logic [CNT_W:0]   occ;
   logic [LW-1:0]    ld_idx;
   logic [LW-1:0]    ld_next;
   logic             ready_ff;
   logic [LW-1:0]    load_cnt_ff;

   logic [CNT_W-1:0] rsp_cnt_ff;
   logic             a_vld_ff;

   assign occ       = (CNT_W + 1)'(rsp_cnt_ff) + (CNT_W + 1)'(a_vld_ff);
   assign req_stall = cmd.hold || (occ > (CNT_W + 1)'(RSP_DEPTH - 1));
   assign req_acc   = req_valid && !req_stall;
   assign ld_acc    = req_acc && (req_data.req_type == REQ_LOAD);
   assign rd_acc    = req_acc && (req_data.req_type == REQ_READ);

   // a load after completion starts a new grid at cell zero
   assign ld_idx  = ready_ff ? '0 : load_cnt_ff;
   assign ld_next = ld_idx + LW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff    <= 1'b0;
         load_cnt_ff <= '0;
      end else begin
         if (ld_acc) begin
            ready_ff    <= 1'b0;
            load_cnt_ff <= ld_next;
         end else if (cmd.set_ready) begin
            ready_ff <= 1'b1;
         end
      end
   end

   // ---------------- load pipeline: word mod 100 vs fill ----------------
   logic [FOLD_W-1:0] fold;
   logic              l1_vld_ff;
   logic [FOLD_W-1:0] l1_sum_ff;
   logic [AW-1:0]     l1_idx_ff;
   logic [MW-1:0]     l1_prod;
   logic              l2_vld_ff;
   logic [FOLD_W-1:0] l2_sum_ff;
   logic [QUO_W-1:0]  l2_quo_ff;
   logic [AW-1:0]     l2_idx_ff;
   logic [FOLD_W-1:0] l2_rem;
   logic              l2_bit;

   assign fold = FOLD_W'(req_data.rand_word[7:0])
               + FOLD_W'(req_data.rand_word[15:8])  * FOLD_W'(BYTE1_WEIGHT)
               + FOLD_W'(req_data.rand_word[23:16]) * FOLD_W'(BYTE2_WEIGHT)
               + FOLD_W'(req_data.rand_word[31:24]) * FOLD_W'(BYTE3_WEIGHT);

   assign l1_prod = MW'(l1_sum_ff) * MW'(RECIP_MUL);
   assign l2_rem  = l2_sum_ff - FOLD_W'(l2_quo_ff) * FOLD_W'(PERCENT_MOD);
   assign l2_bit  = l2_rem < FOLD_W'(cfg.fill_percent);

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_vld_ff <= 1'b0;
         l2_vld_ff <= 1'b0;
      end else begin
         l1_vld_ff <= ld_acc;
         l2_vld_ff <= l1_vld_ff;
      end
      l1_sum_ff <= fold;
      l1_idx_ff <= AW'(ld_idx);
      l2_sum_ff <= l1_sum_ff;
      l2_quo_ff <= QUO_W'(l1_prod >> RECIP_SHIFT);
      l2_idx_ff <= l1_idx_ff;
   end

   // ---------------- sweep state ----------------
   logic [3:0]    pass_left_ff;
   logic [HW-1:0] row_ff;
   logic [WW-1:0] col_ff;
   logic [AW-1:0] base_ff;
   logic [2:0]    left_ff;
   logic [2:0]    mid_ff;
   logic [2:0]    right_ff;
   logic          fetch_vld_ff;
   cca_step_type  fetch_step_ff;
   logic          fetch_oob_ff;
   logic          bank_ff;

   logic          col_last;
   logic          row_last;
   logic          fetch_oob;
   logic [AW-1:0] fetch_addr;
   logic [3:0]    nbr_cnt;
   logic          sweep_wr;
   logic          rd_bit;

   assign col_last = (col_ff == w_eff);
   assign row_last = (row_ff == (h_eff - HW'(1)));

   always_comb begin
      case (cmd.fetch_step)
         STEP_ABOVE: begin
            fetch_addr = base_ff - AW'(w_eff) + AW'(col_ff);
            fetch_oob  = col_last || (row_ff == '0);
         end
         STEP_SAME: begin
            fetch_addr = base_ff + AW'(col_ff);
            fetch_oob  = col_last;
         end
         STEP_BELOW: begin
            fetch_addr = base_ff + AW'(w_eff) + AW'(col_ff);
            fetch_oob  = col_last || row_last;
         end
         default: begin
            fetch_addr = base_ff;
            fetch_oob  = 1'b1;
         end
      endcase
   end

   // eight neighbors: left and right columns plus above/below of the center
   assign nbr_cnt = 4'(left_ff[0]) + 4'(left_ff[1]) + 4'(left_ff[2])
                  + 4'(mid_ff[0]) + 4'(mid_ff[2])
                  + 4'(right_ff[0]) + 4'(right_ff[1]) + 4'(right_ff[2]);

   assign sweep_wr = cmd.calc && (col_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         fetch_vld_ff <= 1'b0;
         bank_ff      <= 1'b0;
      end else begin
         fetch_vld_ff <= cmd.fetch;
         if (cmd.pass_next) begin
            bank_ff <= ~bank_ff;
         end
      end
      fetch_step_ff <= cmd.fetch_step;
      fetch_oob_ff  <= fetch_oob;

      if (cmd.pass_init) begin
         pass_left_ff <= cfg.pass_count;
      end else if (cmd.pass_next) begin
         pass_left_ff <= pass_left_ff - 4'd1;
      end

      if (fetch_vld_ff) begin
         case (fetch_step_ff)
            STEP_ABOVE: right_ff[0] <= fetch_oob_ff | rd_bit;
            STEP_SAME:  right_ff[1] <= fetch_oob_ff | rd_bit;
            STEP_BELOW: right_ff[2] <= fetch_oob_ff | rd_bit;
            default: ;
         endcase
      end

      // column left of the grid counts as wall
      if (cmd.pass_begin) begin
         row_ff  <= '0;
         base_ff <= '0;
         col_ff  <= '0;
         mid_ff  <= 3'b111;
      end else if (cmd.row_next) begin
         row_ff  <= row_ff + HW'(1);
         base_ff <= base_ff + AW'(w_eff);
         col_ff  <= '0;
         mid_ff  <= 3'b111;
      end else if (cmd.calc) begin
         left_ff <= mid_ff;
         mid_ff  <= right_ff;
         col_ff  <= col_ff + WW'(1);
      end
   end

   // ---------------- cell memory ----------------
   logic          bank0_mem [CELLS];
   logic          bank1_mem [CELLS];
   logic          rd0_ff;
   logic          rd1_ff;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic          wr_en;
   logic          wr_bank;
   logic          wr_bit;
   logic [RW-1:0] req_lin;

   assign req_lin = RW'(req_data.read_y) * RW'(w_eff) + RW'(req_data.read_x);
   assign rd_addr = cmd.hold ? fetch_addr : AW'(req_lin);

   always_comb begin
      if (sweep_wr) begin
         wr_en   = 1'b1;
         wr_addr = base_ff + AW'(col_ff) - AW'(1);
         wr_bank = ~bank_ff;
         wr_bit  = (nbr_cnt >= cfg.wall_threshold);
      end else begin
         wr_en   = l2_vld_ff;
         wr_addr = l2_idx_ff;
         wr_bank = bank_ff;
         wr_bit  = l2_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && !wr_bank) begin
         bank0_mem[wr_addr] <= wr_bit;
      end
      if (wr_en && wr_bank) begin
         bank1_mem[wr_addr] <= wr_bit;
      end
      rd0_ff <= bank0_mem[rd_addr];
      rd1_ff <= bank1_mem[rd_addr];
   end

   assign rd_bit = bank_ff ? rd1_ff : rd0_ff;

   // ---------------- read result stage ----------------
   logic        a_nr_ff;
   logic        a_oob_ff;
   cca_rsp_type a_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= rd_acc;
      end
      a_nr_ff  <= !ready_ff;
      a_oob_ff <= (XW'(req_data.read_x) >= XW'(w_eff))
               || (YW'(req_data.read_y) >= YW'(h_eff));
   end

   assign a_rsp.not_ready = a_nr_ff;
   assign a_rsp.wall      = !a_nr_ff && (a_oob_ff || rd_bit);

   // ---------------- response queue ----------------
   cca_rsp_type      rsp_mem [RSP_DEPTH];
   logic [PTR_W-1:0] wptr_ff;
   logic [PTR_W-1:0] rptr_ff;
   logic             push;
   logic             pop;

   assign push      = a_vld_ff;
   assign rsp_valid = (rsp_cnt_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = rsp_mem[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff    <= '0;
         rptr_ff    <= '0;
         rsp_cnt_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= wptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rptr_ff <= rptr_ff + PTR_W'(1);
         end
         rsp_cnt_ff <= rsp_cnt_ff + CNT_W'(push) - CNT_W'(pop);
      end
      if (push) begin
         rsp_mem[wptr_ff] <= a_rsp;
      end
   end

   // ---------------- status ----------------
   assign stat.load_last = ld_acc && (PW'(ld_next) >= total);
   assign stat.load_busy = l1_vld_ff || l2_vld_ff;
   assign stat.pass_zero = (pass_left_ff == 4'd0);
   assign stat.col_last  = col_last;
   assign stat.row_last  = row_last;

endmodule

`default_nettype wire

// ===== rtl/core/cave_cellular_automaton_unit.sv =====
// ----------------------------------------------------------------------------
// cave_cellular_automaton_unit: cave map generator by cellular automaton
// Loads one random word per cell, relaxes the grid, then answers cell reads.
// ----------------------------------------------------------------------------
// Loads and reads are accepted one per cycle unless the input stalls (sweep
// or full response queue); a read result passes a result stage and a
// four-entry response queue before it shows on rsp. After the last cell
// loads, the input stalls while the load pipe drains and pass_count passes run;
// each column costs three single-port reads of the live bank, a wait for the
// registered read data and an update/write.
// Synchronous reset clears the ready flag, load counter, bank pointer and
// pipelines; the cell memory is not cleared and reads of unloaded cells are
// undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module cave_cellular_automaton_unit
   import cca_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel: load a cell word or read a cell
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire cca_req_type       req_data,
   // response channel: one result per read request
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output cca_rsp_type            rsp_data,
   // configuration port
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [CSR_DW-1:0] pwdata,
   output logic      [CSR_DW-1:0] prdata,
   output logic                   pready
);

   cca_cfg_type  cfg;
   cca_cmd_type  cmd;
   cca_stat_type stat;

   // register file; values apply to whatever grid is in use
   cca_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer: drains the load pipe, then steps passes, rows and columns
   cca_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   // memory banks, load pipe, sweep window and response queue
   cca_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .stat      (stat),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // the request that completes the grid closes the input for the sweep
   a_last_load_stalls: assert property (
      @(posedge clock) disable iff (reset)
      stat.load_last |=> req_stall
   ) else $error("input open after grid completed");

   // sweep updates never race pending load writes
   a_calc_after_drain: assert property (
      @(posedge clock) disable iff (reset)
      cmd.calc |-> !stat.load_busy
   ) else $error("sweep update while load pipe busy");

   // grid is declared ready only once every load write has landed
   a_ready_after_drain: assert property (
      @(posedge clock) disable iff (reset)
      cmd.set_ready |-> (!stat.load_busy && cmd.hold)
   ) else $error("grid ready with load pipe busy");

endmodule

`default_nettype wire

// ===== dv/cave_cellular_automaton_unit_test.sv =====
// ----------------------------------------------------------------------------
// cave_cellular_automaton_unit_test: self-checking bench for the cave unit
// Loads cave grids cell by cell, reads cells back and checks every read
// response against a behavioral cave model kept in the bench. Registers are
// programmed over the APB port between phases. Both channels idle at random,
// and the receiver holds off long enough to back the unit up.
// ----------------------------------------------------------------------------
module cave_cellular_automaton_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import cca_pkg::*;

   localparam int GRID_MAX_W   = MAX_WIDTH_DEF;
   localparam int GRID_MAX_H   = MAX_HEIGHT_DEF;
   localparam int CAVE_CELLS   = GRID_MAX_W * GRID_MAX_H;
   localparam int PERCENT      = 100;
   // Slowest relaxation used here is a 12x10 grid with 15 passes; the limit
   // also clears the longest receiver hold-off by a wide margin.
   localparam int QUIET_LIMIT  = 100000;
   localparam int LONG_HOLD    = 300;
   localparam int RANDOM_UNTIL = 380;

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   cca_req_type       req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   cca_rsp_type       rsp_data;
   logic              psel      = 1'b0;
   logic              penable   = 1'b0;
   logic              pwrite    = 1'b0;
   logic [CSR_AW-1:0] paddr     = '0;
   logic [CSR_DW-1:0] pwdata    = '0;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   cave_cellular_automaton_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ------------------------------------------------------------------------
   // Cave model: register shadow, two cell banks, load counter, live bank
   // ------------------------------------------------------------------------
   logic [7:0]  cfg_width;
   logic [7:0]  cfg_height;
   logic [3:0]  cfg_passes;
   logic [6:0]  cfg_fill;
   logic [3:0]  cfg_threshold;

   bit          cave_bank [2][CAVE_CELLS];
   int unsigned cells_loaded;
   bit          live_bank;
   bit          cave_ready;

   cca_rsp_type expected_cells[$];

   longint unsigned cycle_count   = 0;
   // cycle by which the last relaxation must be over
   longint unsigned relax_done_at = 0;
   int              quiet_cycles  = 0;
   int              error_count   = 0;
   int              requests_sent = 0;

   // idling controls
   bit sender_pauses    = 1'b1;
   bit receiver_pauses  = 1'b1;
   bit hold_off_request = 1'b0;
   int hold_left        = 0;
   int burst_left       = 0;

   // zero reads as one, anything past the array saturates
   function automatic int cave_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > GRID_MAX_W) return GRID_MAX_W;
      return cfg_width;
   endfunction

   function automatic int cave_height();
      if (cfg_height == 0) return 1;
      if (cfg_height > GRID_MAX_H) return GRID_MAX_H;
      return cfg_height;
   endfunction

   // cells off the grid count as wall
   function automatic int wall_neighbors(bit src, int w, int h, int x, int y);
      int n;
      int dx;
      int dy;
      int cx;
      int cy;
      n = 0;
      for (dy = -1; dy <= 1; dy++) begin
         for (dx = -1; dx <= 1; dx++) begin
            if (dx == 0 && dy == 0) continue;
            cx = x + dx;
            cy = y + dy;
            if (cx < 0 || cy < 0 || cx >= w || cy >= h) n++;
            else if (cave_bank[src][cy * w + cx]) n++;
         end
      end
      return n;
   endfunction

   // Ping-pong between the banks, one pass per step. Also notes when the
   // unit should be done.
   function automatic void relax_cave();
      int w;
      int h;
      int p;
      int x;
      int y;
      bit src;
      w = cave_width();
      h = cave_height();
      for (p = 0; p < cfg_passes; p++) begin
         src = live_bank;
         for (y = 0; y < h; y++)
            for (x = 0; x < w; x++)
               cave_bank[~src][y * w + x] = (wall_neighbors(src, w, h, x, y) >= cfg_threshold);
         live_bank = ~src;
      end
      cave_ready    = 1'b1;
      relax_done_at = cycle_count + 3 + 16 + cfg_passes * (1 + h * (w + 1) * 5);
   endfunction

   function automatic void predict_cave(cca_req_type r);
      int w;
      int h;
      cca_rsp_type resp;
      w = cave_width();
      h = cave_height();
      if (r.req_type == REQ_LOAD) begin
         // a load after completion starts a fresh grid
         if (cave_ready) begin
            cave_ready   = 1'b0;
            cells_loaded = 0;
         end
         if (cells_loaded < CAVE_CELLS)
            cave_bank[live_bank][cells_loaded] = (r.rand_word % PERCENT) < cfg_fill;
         cells_loaded++;
         if (cells_loaded >= w * h) relax_cave();
      end else begin
         if (!cave_ready) begin
            resp.wall      = 1'b0;
            resp.not_ready = 1'b1;
         end else if (r.read_x >= w || r.read_y >= h) begin
            resp.wall      = 1'b1;
            resp.not_ready = 1'b0;
         end else begin
            resp.wall      = cave_bank[live_bank][r.read_y * w + r.read_x];
            resp.not_ready = 1'b0;
         end
         expected_cells.push_back(resp);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Response checker: in-order compare against the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_responses
      cca_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_cells.size() == 0) begin
            $error("response with nothing outstanding: wall=%0d not_ready=%0d",
                   rsp_data.wall, rsp_data.not_ready);
            error_count++;
         end else begin
            want = expected_cells.pop_front();
            if (rsp_data.wall !== want.wall) begin
               $error("wall: expected %0d, actual %0d", want.wall, rsp_data.wall);
               error_count++;
            end
            if (rsp_data.not_ready !== want.not_ready) begin
               $error("not_ready: expected %0d, actual %0d", want.not_ready,
                      rsp_data.not_ready);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random stall bursts, plus one long hold-off
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_off_request) begin
         hold_left        = LONG_HOLD;
         hold_off_request = 1'b0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (burst_left > 0) begin
         rsp_stall <= 1'b1;
         burst_left--;
      end else if (receiver_pauses && $urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         burst_left = $urandom_range(0, 7);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: too long without any handshake on either channel ends the run
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Request driver. Valid stays up after acceptance so back-to-back calls
   // stream; the caller either sends again at once or drops valid.
   // ------------------------------------------------------------------------
   task automatic send_request(input cca_req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_cave(r);
      requests_sent++;
      if (sender_pauses && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // unused fields carry random junk
   task automatic load_cell(input logic [31:0] word);
      cca_req_type r;
      r.req_type  = REQ_LOAD;
      r.rand_word = word;
      r.read_x    = 7'($urandom);
      r.read_y    = 7'($urandom);
      send_request(r);
   endtask

   task automatic read_cell(input int x, input int y);
      cca_req_type r;
      r.req_type  = REQ_READ;
      r.rand_word = $urandom;
      r.read_x    = 7'(x);
      r.read_y    = 7'(y);
      send_request(r);
   endtask

   // Drop valid, wait for every outstanding read and for any relaxation
   // still running, so the unit is idle for register writes.
   task automatic settle_cave();
      req_valid <= 1'b0;
      while (expected_cells.size() != 0 || cycle_count < relax_done_at) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // setup phase, access phase, then psel low before the next write
   task automatic write_register(input cca_reg_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_GRID_WIDTH:     cfg_width     = value[7:0];
         REG_GRID_HEIGHT:    cfg_height    = value[7:0];
         REG_PASS_COUNT:     cfg_passes    = value[3:0];
         REG_FILL_PERCENT:   cfg_fill      = value[6:0];
         REG_WALL_THRESHOLD: cfg_threshold = value[3:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic configure_cave(input int w, input int h, input int passes,
                                 input int fill, input int threshold);
      settle_cave();
      write_register(REG_GRID_WIDTH, w);
      write_register(REG_GRID_HEIGHT, h);
      write_register(REG_PASS_COUNT, passes);
      write_register(REG_FILL_PERCENT, fill);
      write_register(REG_WALL_THRESHOLD, threshold);
   endtask

   // Load a full grid with random words, a stray read now and then while
   // it is still loading, then read a batch of cells, mostly on the grid.
   // No stray read while an older grid is still live: the registers may
   // have grown past what that grid filled in.
   task automatic grow_random_cave();
      do begin
         if (!cave_ready && $urandom_range(0, 7) == 0)
            read_cell($urandom_range(0, 127), $urandom_range(0, 127));
         load_cell($urandom);
      end while (!cave_ready);
      repeat ($urandom_range(3, 14)) begin
         if ($urandom_range(0, 3) != 0)
            read_cell($urandom_range(0, cave_width() - 1), $urandom_range(0, cave_height() - 1));
         else
            read_cell($urandom_range(0, 127), $urandom_range(0, 127));
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // nothing loaded yet: every read is flagged not ready
   task automatic test_read_before_load();
      read_cell(0, 0);
      read_cell(127, 127);
      settle_cave();
   endtask

   // zero width/height act as a 1x1 grid whose neighbors are all wall
   task automatic test_single_cell();
      configure_cave(0, 0, 1, 100, 8);
      load_cell(32'hFFFF_FFFF);
      read_cell(0, 0);
      read_cell(1, 0);
      read_cell(0, 127);
      // no passes: ready straight after the load, fill 0 gives floor
      configure_cave(0, 0, 0, 0, 8);
      load_cell(32'h0000_0000);
      read_cell(0, 0);
      settle_cave();
   endtask

   // fill over 100 makes all wall; threshold over 8 clears all; max passes
   task automatic test_fill_threshold_extremes();
      configure_cave(2, 2, 15, 127, 15);
      load_cell(32'h0000_0000);
      load_cell(32'hFFFF_FFFF);
      load_cell(32'd12345);
      load_cell(32'h8000_0000);
      read_cell(1, 1);
      read_cell(0, 0);
      // threshold zero walls every cell in one pass
      configure_cave(2, 1, 1, 0, 0);
      load_cell(32'hFFFF_FFFF);
      load_cell(32'h0000_0000);
      read_cell(1, 0);
      settle_cave();
   endtask

   // grid grows during loading, then shrinks once ready
   task automatic test_registers_mid_operation();
      configure_cave(2, 1, 1, 50, 3);
      load_cell(32'd10);
      read_cell(0, 0);
      settle_cave();
      write_register(REG_GRID_HEIGHT, 2);
      load_cell(32'd70);
      load_cell(32'd20);
      load_cell(32'd99);
      read_cell(1, 1);
      settle_cave();
      write_register(REG_GRID_WIDTH, 1);
      read_cell(0, 1);
      read_cell(1, 0);
      settle_cave();
   endtask

   // oversized width and height saturate to the array size
   task automatic test_grid_saturation();
      configure_cave(255, 1, 2, 45, 4);
      repeat (GRID_MAX_W) load_cell($urandom);
      read_cell(0, 0);
      read_cell(127, 0);
      read_cell(64, 0);
      read_cell(5, 1);
      configure_cave(1, 200, 1, 55, 5);
      repeat (GRID_MAX_H) load_cell($urandom);
      read_cell(0, 127);
      read_cell(0, 0);
      read_cell(1, 5);
      settle_cave();
   endtask

   // random small grids; config sometimes kept so a load restarts the grid
   task automatic test_random_caves();
      while (requests_sent < RANDOM_UNTIL) begin
         if ($urandom_range(0, 3) != 0)
            configure_cave($urandom_range(0, 12), $urandom_range(0, 10),
                           $urandom_range(0, 15),
                           ($urandom_range(0, 2) == 0) ? $urandom_range(0, 127)
                                                       : $urandom_range(35, 60),
                           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(3, 5));
         sender_pauses   = ($urandom_range(0, 3) != 0);
         receiver_pauses = ($urandom_range(0, 3) != 0);
         grow_random_cave();
      end
      settle_cave();
   endtask

   // receiver holds off while reads keep coming: queue fills, input stalls
   task automatic test_long_hold_off();
      configure_cave(5, 4, 2, 45, 4);
      sender_pauses   = 1'b0;
      receiver_pauses = 1'b0;
      grow_random_cave();
      hold_off_request = 1'b1;
      repeat (40) read_cell($urandom_range(0, 4), $urandom_range(0, 3));
      settle_cave();
   endtask

   // closing stretch at full rate on both sides
   task automatic test_full_rate();
      sender_pauses   = 1'b0;
      receiver_pauses = 1'b0;
      configure_cave(6, 5, 3, 45, 4);
      grow_random_cave();
      grow_random_cave();
      settle_cave();
   endtask

   initial begin
      // register reset values, empty model
      cfg_width     = GRID_WIDTH_RST;
      cfg_height    = GRID_HEIGHT_RST;
      cfg_passes    = PASS_COUNT_RST;
      cfg_fill      = FILL_PERCENT_RST;
      cfg_threshold = WALL_THRESHOLD_RST;
      cells_loaded  = 0;
      live_bank     = 1'b0;
      cave_ready    = 1'b0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_read_before_load();
      test_single_cell();
      test_fill_threshold_extremes();
      test_registers_mid_operation();
      test_grid_saturation();
      test_random_caves();
      test_long_hold_off();
      test_full_rate();

      settle_cave();
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_cells.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
